[rtl/core/cvp_pkg.sv]
package cvp_pkg;

    // parameter defaults
    localparam int MAX_DIM_DEF       = 4096;
    localparam int CORDIC_STAGES_DEF = 16;

    // field and datapath widths
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int DIFF_W    = 13;
    localparam int SQ_W      = 24;
    localparam int D2_W      = 26;
    localparam int SQ_PAIRS  = (D2_W + 32) / 2;
    localparam int ROOT_W    = SQ_PAIRS;
    localparam int REM_W     = 33;
    localparam int DIVD_W    = ROOT_W + 4;
    localparam int RAD_W     = 16;
    localparam int PHASE_W   = 18;
    localparam int Q_W       = 16;
    localparam int X_W       = 34;
    localparam int Z_W       = 20;
    localparam int COS_W     = 32;
    localparam int PROD_W    = Q_W + COS_W;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [X_W-1:0]   CORDIC_X0 = 34'sd652032874;
    localparam logic signed [COS_W-1:0] UNIT_Q30  = 32'sd1073741824;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_FALLOFF_RADIUS = 3'd2,
        CFG_PEAK_GAIN      = 3'd3,
        CFG_LEVEL_BIAS     = 3'd4
    } t_cfg_reg;

    // rotation angle per stage, 2^-16 quarter turn units
    function automatic logic signed [Z_W-1:0] atan_step(input int idx);
        logic signed [Z_W-1:0] v;
        begin
            unique case (idx)
                0:  v = 20'sd32768;
                1:  v = 20'sd19344;
                2:  v = 20'sd10221;
                3:  v = 20'sd5188;
                4:  v = 20'sd2604;
                5:  v = 20'sd1303;
                6:  v = 20'sd652;
                7:  v = 20'sd326;
                8:  v = 20'sd163;
                9:  v = 20'sd81;
                10: v = 20'sd41;
                11: v = 20'sd20;
                12: v = 20'sd10;
                13: v = 20'sd5;
                14: v = 20'sd3;
                15: v = 20'sd1;
                16: v = 20'sd1;
                default: v = 20'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/core/cvp_sqrt_cell.sv]
module cvp_sqrt_cell
    import cvp_pkg::*;
#(
    parameter int PAIR = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [D2_W-1:0]   i_d2,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_valid,
    output logic [D2_W-1:0]   o_d2,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root
);

    localparam int TOP = D2_W + 32 - 1 - 2 * PAIR;

    logic                    r_valid;
    logic [D2_W-1:0]         r_d2;
    logic [REM_W-1:0]        r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic [D2_W+31:0]        w_rad;
    logic [REM_W-1:0]        w_try;
    logic [REM_W-1:0]        w_trial;
    logic [REM_W-1:0]        n_rem;
    logic [ROOT_W-1:0]       n_root;

    // one radicand digit pair per cell
    assign w_rad   = {i_d2, 32'd0};
    assign w_try   = {i_rem[REM_W-3:0], w_rad[TOP -: 2]};
    assign w_trial = {{(REM_W-ROOT_W-2){1'b0}}, i_root, 2'b01};

    always_comb begin
        if (w_try >= w_trial) begin
            n_rem  = w_try - w_trial;
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_try;
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d2   <= i_d2;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_d2    = r_d2;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

[rtl/core/cvp_div_cell.sv]
module cvp_div_cell
    import cvp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic [ROOT_W-1:0]  i_root,
    input  logic [RAD_W-1:0]   i_rem,
    input  logic [PHASE_W-1:0] i_quo,
    output logic               o_valid,
    output logic [ROOT_W-1:0]  o_root,
    output logic [RAD_W-1:0]   o_rem,
    output logic [PHASE_W-1:0] o_quo
);

    logic                r_valid;
    logic [ROOT_W-1:0]   r_root;
    logic [RAD_W-1:0]    r_rem;
    logic [PHASE_W-1:0]  r_quo;
    logic [DIVD_W-1:0]   w_dvd;
    logic [RAD_W:0]      w_try;
    logic [RAD_W:0]      w_diff;
    logic [RAD_W-1:0]    n_rem;
    logic [PHASE_W-1:0]  n_quo;

    // one quotient bit per cell, old high bits fall off (phase wrap)
    assign w_dvd  = {i_root, 4'd0};
    assign w_try  = {i_rem, w_dvd[DIVD_W-1-BIT]};
    assign w_diff = w_try - {1'b0, i_rad};

    always_comb begin
        if (w_try >= {1'b0, i_rad}) begin
            n_rem = w_diff[RAD_W-1:0];
            n_quo = {i_quo[PHASE_W-2:0], 1'b1};
        end else begin
            n_rem = w_try[RAD_W-1:0];
            n_quo = {i_quo[PHASE_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_root <= i_root;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

[rtl/core/cvp_cordic_cell.sv]
module cvp_cordic_cell
    import cvp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [1:0]            i_quad,
    input  logic signed [X_W-1:0] i_x,
    input  logic signed [X_W-1:0] i_y,
    input  logic signed [Z_W-1:0] i_z,
    output logic                  o_valid,
    output logic [1:0]            o_quad,
    output logic signed [X_W-1:0] o_x,
    output logic signed [X_W-1:0] o_y,
    output logic signed [Z_W-1:0] o_z
);

    localparam logic signed [Z_W-1:0] STEP = atan_step(IDX);

    logic                  r_valid;
    logic [1:0]            r_quad;
    logic signed [X_W-1:0] r_x;
    logic signed [X_W-1:0] r_y;
    logic signed [Z_W-1:0] r_z;
    logic signed [X_W-1:0] w_xs;
    logic signed [X_W-1:0] w_ys;
    logic signed [X_W-1:0] n_x;
    logic signed [X_W-1:0] n_y;
    logic signed [Z_W-1:0] n_z;

    // one rotation, direction from the residual angle sign
    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    always_comb begin
        if (!i_z[Z_W-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - STEP;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + STEP;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_quad <= i_quad;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_quad  = r_quad;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

[rtl/core/cosine_vignette_pixel.sv]
// stages: offset, square, sum; root, divide, rotation cells; cosine, product, result
// throughput: one word per cycle; the whole cell chain advances together and
// holds only while the result register is full and the output is stalled
// reset: synchronous active-low, clears all valid bits and loads the register
// defaults (width 256, height 256, radius 2048, gain 256, bias 0)
module cosine_vignette_pixel
    import cvp_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [COORD_W-1:0]   i_pixel_col,
    input  logic [COORD_W-1:0]   i_pixel_row,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [Q_W-1:0] o_shade_value,
    output logic                 o_clipped
);

    localparam logic [17:0] DIM_LIM = 18'(MAX_DIM);

    // configuration registers
    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic [RAD_W-1:0]     r_radius;
    logic signed [Q_W-1:0] r_gain;
    logic signed [Q_W-1:0] r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd256;
            r_height <= 13'd256;
            r_radius <= 16'd2048;
            r_gain   <= 16'sd256;
            r_bias   <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data[DIM_W-1:0];
                CFG_FALLOFF_RADIUS: r_radius <= i_cfg_data;
                CFG_PEAK_GAIN:      r_gain   <= $signed(i_cfg_data);
                CFG_LEVEL_BIAS:     r_bias   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // chain advance
    logic w_adv;
    logic r_out_valid;
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // centre and offsets
    logic [DIM_W-1:0] w_w_eff;
    logic [DIM_W-1:0] w_h_eff;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic [RAD_W-1:0] w_rad;

    assign w_w_eff = (18'(r_width) > DIM_LIM) ? DIM_LIM[DIM_W-1:0] : r_width;
    assign w_h_eff = (18'(r_height) > DIM_LIM) ? DIM_LIM[DIM_W-1:0] : r_height;
    assign w_dx = $signed({1'b0, i_pixel_col}) - $signed({1'b0, w_w_eff[DIM_W-1:1]});
    assign w_dy = $signed({1'b0, i_pixel_row}) - $signed({1'b0, w_h_eff[DIM_W-1:1]});
    assign w_rad = (r_radius == '0) ? 16'd1 : r_radius;

    logic r_a_valid, r_b_valid, r_c_valid;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy;
    logic [SQ_W-1:0] r_b_sx, r_b_sy;
    logic [D2_W-1:0] r_c_d2;
    logic signed [2*DIFF_W-1:0] w_sx, w_sy;

    assign w_sx = r_a_dx * r_a_dx;
    assign w_sy = r_a_dy * r_a_dy;

    // front stages valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // offsets, squares, squared distance
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_dx <= w_dx;
            r_a_dy <= w_dy;
            r_b_sx <= w_sx[SQ_W-1:0];
            r_b_sy <= w_sy[SQ_W-1:0];
            r_c_d2 <= D2_W'(r_b_sx) + D2_W'(r_b_sy);
        end
    end

    // square root chain, two radicand bits per cell
    logic              w_sq_valid [0:SQ_PAIRS];
    logic [D2_W-1:0]   w_sq_d2    [0:SQ_PAIRS];
    logic [REM_W-1:0]  w_sq_rem   [0:SQ_PAIRS];
    logic [ROOT_W-1:0] w_sq_root  [0:SQ_PAIRS];

    assign w_sq_valid[0] = r_c_valid;
    assign w_sq_d2[0]    = r_c_d2;
    assign w_sq_rem[0]   = '0;
    assign w_sq_root[0]  = '0;

    for (genvar g = 0; g < SQ_PAIRS; g++) begin : g_sqrt
        cvp_sqrt_cell #(.PAIR(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_sq_valid[g]),
            .i_d2    (w_sq_d2[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_d2    (w_sq_d2[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1])
        );
    end

    // divider chain, one quotient bit per cell
    logic               w_dv_valid [0:DIVD_W];
    logic [ROOT_W-1:0]  w_dv_root  [0:DIVD_W];
    logic [RAD_W-1:0]   w_dv_rem   [0:DIVD_W];
    logic [PHASE_W-1:0] w_dv_quo   [0:DIVD_W];

    assign w_dv_valid[0] = w_sq_valid[SQ_PAIRS];
    assign w_dv_root[0]  = w_sq_root[SQ_PAIRS];
    assign w_dv_rem[0]   = '0;
    assign w_dv_quo[0]   = '0;

    for (genvar g = 0; g < DIVD_W; g++) begin : g_div
        cvp_div_cell #(.BIT(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_dv_valid[g]),
            .i_rad   (w_rad),
            .i_root  (w_dv_root[g]),
            .i_rem   (w_dv_rem[g]),
            .i_quo   (w_dv_quo[g]),
            .o_valid (w_dv_valid[g+1]),
            .o_root  (w_dv_root[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_quo   (w_dv_quo[g+1])
        );
    end

    // rotation chain
    logic                  w_cr_valid [0:CORDIC_STAGES];
    logic [1:0]            w_cr_quad  [0:CORDIC_STAGES];
    logic signed [X_W-1:0] w_cr_x     [0:CORDIC_STAGES];
    logic signed [X_W-1:0] w_cr_y     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0] w_cr_z     [0:CORDIC_STAGES];

    assign w_cr_valid[0] = w_dv_valid[DIVD_W];
    assign w_cr_quad[0]  = w_dv_quo[DIVD_W][PHASE_W-1:PHASE_W-2];
    assign w_cr_x[0]     = CORDIC_X0;
    assign w_cr_y[0]     = '0;
    assign w_cr_z[0]     = $signed({{(Z_W-PHASE_W+2){1'b0}}, w_dv_quo[DIVD_W][PHASE_W-3:0]});

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        cvp_cordic_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_cr_valid[g]),
            .i_quad  (w_cr_quad[g]),
            .i_x     (w_cr_x[g]),
            .i_y     (w_cr_y[g]),
            .i_z     (w_cr_z[g]),
            .o_valid (w_cr_valid[g+1]),
            .o_quad  (w_cr_quad[g+1]),
            .o_x     (w_cr_x[g+1]),
            .o_y     (w_cr_y[g+1]),
            .o_z     (w_cr_z[g+1])
        );
    end

    // clamp to unit and map quadrant
    logic signed [X_W-1:0]   w_x_end, w_y_end;
    logic signed [COS_W-1:0] w_xc, w_yc, n_cos;

    assign w_x_end = w_cr_x[CORDIC_STAGES];
    assign w_y_end = w_cr_y[CORDIC_STAGES];

    always_comb begin
        if (w_x_end > X_W'(UNIT_Q30)) begin
            w_xc = UNIT_Q30;
        end else if (w_x_end < -X_W'(UNIT_Q30)) begin
            w_xc = -UNIT_Q30;
        end else begin
            w_xc = w_x_end[COS_W-1:0];
        end
        if (w_y_end > X_W'(UNIT_Q30)) begin
            w_yc = UNIT_Q30;
        end else if (w_y_end < -X_W'(UNIT_Q30)) begin
            w_yc = -UNIT_Q30;
        end else begin
            w_yc = w_y_end[COS_W-1:0];
        end
        unique case (w_cr_quad[CORDIC_STAGES])
            2'd0:    n_cos = w_xc;
            2'd1:    n_cos = -w_yc;
            2'd2:    n_cos = -w_xc;
            default: n_cos = w_yc;
        endcase
    end

    // gain, rounding, bias and saturation
    logic r_cos_valid, r_prod_valid;
    logic signed [COS_W-1:0]  r_cos;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [PROD_W-31:0] w_scaled;
    logic signed [PROD_W-30:0] w_sum;
    logic signed [Q_W-1:0]    n_shade;
    logic                     n_clip;
    logic signed [Q_W-1:0]    r_shade;
    logic                     r_clip;

    assign w_rnd    = r_prod + PROD_W'(64'sd536870912);
    assign w_scaled = w_rnd[PROD_W-1:30];
    assign w_sum    = (PROD_W-29)'(w_scaled) + (PROD_W-29)'(r_bias);

    always_comb begin
        if (w_sum > (PROD_W-29)'(32767)) begin
            n_shade = 16'sh7fff;
            n_clip  = 1'b1;
        end else if (w_sum < -(PROD_W-29)'(32768)) begin
            n_shade = 16'sh8000;
            n_clip  = 1'b1;
        end else begin
            n_shade = w_sum[Q_W-1:0];
            n_clip  = 1'b0;
        end
    end

    // back stages valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (w_adv) begin
            r_cos_valid  <= w_cr_valid[CORDIC_STAGES];
            r_prod_valid <= r_cos_valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cos   <= n_cos;
            r_prod  <= r_gain * r_cos;
            r_shade <= n_shade;
            r_clip  <= n_clip;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_shade_value = r_shade;
    assign o_clipped     = r_clip;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
        (o_shade_value == 16'sh7fff || o_shade_value == 16'sh8000))
        else $error("clip flag without saturated value");

    a_cos_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cos_valid |-> (r_cos <= UNIT_Q30 && r_cos >= -UNIT_Q30))
        else $error("cosine outside unit range");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_prod_valid)))
        else $error("chain moved while result stalled");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cvp_pkg::*;

    // expected shade values, computed per accepted pixel word
    class shade_scoreboard;
        typedef struct {
            logic signed [Q_W-1:0] shade;
            logic                  clip;
        } t_shade;

        t_shade                 expected_q[$];
        int                     errors;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
        logic [RAD_W-1:0]       radius;
        logic signed [Q_W-1:0]  gain;
        logic signed [Q_W-1:0]  bias;
        int                     atan_tab[ANGLE_TABLE_LEN] = '{
            32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0};

        function new();
            errors = 0;
            width  = 13'd256;
            height = 13'd256;
            radius = 16'd2048;
            gain   = 16'sd256;
            bias   = 16'sd0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [15:0] v);
            case (idx)
                CFG_IMAGE_WIDTH:    width  = v[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   height = v[DIM_W-1:0];
                CFG_FALLOFF_RADIUS: radius = v;
                CFG_PEAK_GAIN:      gain   = v;
                CFG_LEVEL_BIAS:     bias   = v;
                default: ;
            endcase
        endfunction

        // bitwise integer square root
        function longint unsigned int_root(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // cosine of an 18 bit quarter-turn phase, Q.30
        function longint cos_q30(logic [PHASE_W-1:0] phase);
            longint x, y, z, xs, ys, st;
            x = 64'sd652032874;
            y = 64'sd0;
            z = longint'(phase[15:0]);
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
                st = (i < ANGLE_TABLE_LEN) ? longint'(atan_tab[i]) : 64'sd0;
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - st;
                end else begin
                    x = x + ys; y = y - xs; z = z + st;
                end
            end
            if (x > 64'sd1073741824) x = 64'sd1073741824;
            if (x < -64'sd1073741824) x = -64'sd1073741824;
            if (y > 64'sd1073741824) y = 64'sd1073741824;
            if (y < -64'sd1073741824) y = -64'sd1073741824;
            case (phase[17:16])
                2'd0: return x;
                2'd1: return -y;
                2'd2: return -x;
                default: return y;
            endcase
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
            longint w, h, dx, dy, c, p, s;
            longint unsigned d2, r, rad;
            logic [PHASE_W-1:0] phase;
            t_shade e;
            w = (width > 13'd4096) ? 64'sd4096 : longint'(width);
            h = (height > 13'd4096) ? 64'sd4096 : longint'(height);
            dx = longint'(col) - w / 2;
            dy = longint'(row) - h / 2;
            d2 = dx * dx + dy * dy;
            r = int_root(d2 << 32);
            rad = (radius == 0) ? 64'd1 : 64'(radius);
            phase = PHASE_W'(((r * 16) / rad) & 64'h3FFFF);
            c = cos_q30(phase);
            p = (longint'(gain) * c + (64'sd1 << 29)) >>> 30;
            s = p + longint'(bias);
            e.clip = 1'b0;
            if (s > 32767) begin s = 32767; e.clip = 1'b1; end
            if (s < -32768) begin s = -32768; e.clip = 1'b1; end
            e.shade = s[15:0];
            expected_q.push_back(e);
        endfunction

        function void check_shade(logic signed [Q_W-1:0] shade, logic clip);
            t_shade e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word shade=%0d clipped=%0b", $time, shade, clip);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (shade !== e.shade) begin
                $display("%0t: shade expected %0d actual %0d", $time, e.shade, shade);
                errors++;
            end
            if (clip !== e.clip) begin
                $display("%0t: clipped expected %0b actual %0b", $time, e.clip, clip);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [15:0]            i_cfg_data = '0;
    logic                   i_in_valid = 0;
    logic                   o_in_stall;
    logic [COORD_W-1:0]     i_pixel_col = '0;
    logic [COORD_W-1:0]     i_pixel_row = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 0;
    logic signed [Q_W-1:0]  o_shade_value;
    logic                   o_clipped;

    shade_scoreboard sb = new();
    int  burst_left = 4;
    bit  no_gaps = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  stall_pct = 0;
    int  idle_cycles = 0;

    cosine_vignette_pixel dut (.*);

    // clock
    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // accepted words on both sides, plus watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_pixel(i_pixel_col, i_pixel_row);
            if (o_out_valid && !i_out_stall) sb.check_shade(o_shade_value, o_clipped);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1;
        end else begin
            if (($urandom & 63) == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic cfg_write(t_cfg_reg idx, logic [15:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    // drain everything, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 0;
        i_cfg_we <= 0;
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [15:0] w, logic [15:0] h, logic [15:0] rad,
                             logic [15:0] g, logic [15:0] b);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_FALLOFF_RADIUS, rad);
        cfg_write(CFG_PEAK_GAIN, g);
        cfg_write(CFG_LEVEL_BIAS, b);
        i_cfg_we <= 0;
    endtask

    // one pixel word, then maybe a gap between bursts
    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        i_in_valid <= 1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (o_in_stall);
        if (!no_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_in_valid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 10);
            end
        end
    endtask

    // random pixels, mostly inside the image
    task automatic send_random(int n);
        int w, h;
        for (int k = 0; k < n; k++) begin
            w = (sb.width > 13'd4096) ? 4096 :
                ((sb.width == 0) ? 1 : int'(sb.width));
            h = (sb.height > 13'd4096) ? 4096 :
                ((sb.height == 0) ? 1 : int'(sb.height));
            if ($urandom_range(0, 3) != 0)
                send_pixel(COORD_W'($urandom_range(0, w - 1)),
                           COORD_W'($urandom_range(0, h - 1)));
            else
                send_pixel(COORD_W'($urandom_range(0, 4095)),
                           COORD_W'($urandom_range(0, 4095)));
        end
    endtask

    function automatic logic [15:0] rand_radius();
        return ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 255))
                                           : 16'($urandom_range(256, 65535));
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // default registers: corners, centre, alternating-bit coordinates
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd128, 12'd128);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd129, 12'd128);
        send_pixel(12'd128, 12'd2176);
        send_random(60);

        // oversized width, zero height, zero radius, full positive gain and bias
        load_regs(16'd8191, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
        send_pixel(12'd2048, 12'd0);
        send_pixel(12'd2049, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_random(30);

        // narrow image, largest radius, most negative gain and bias
        load_regs(16'd1, 16'd4096, 16'hFFFF, 16'h8000, 16'h8000);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_random(30);

        // long receiver hold-off while the sender keeps offering
        load_regs(16'd640, 16'd480, 16'd400, 16'd256, 16'd0);
        no_gaps = 1;
        hold_req = 1;
        send_random(250);
        no_gaps = 0;

        // random register settings
        for (int ph = 0; ph < 8; ph++) begin
            load_regs(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                      rand_radius(),
                      16'($urandom_range(0, 65535)),
                      ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(0, 511) - 256));
            send_random(30);
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
